### src/lse_pkg.sv
// ----------------------------------------------------------------------------
// lse_pkg
// Shared constants, codes and controller/datapath interface types for the
// LED segment effect engine.
// ----------------------------------------------------------------------------
package lse_pkg;

	// Default structural parameters.
	localparam int DEF_SEGS_PER_STRIP = 8;
	localparam int DEF_LED_INDEX_BITS = 7;

	// Fixed width of the LED range fields on the result port.
	localparam int RANGE_W = 7;

	// Request types.
	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_MODE   = 2'd1;
	localparam logic [1:0] REQ_BOUNDS = 2'd2;

	// Segment modes.
	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_ON    = 2'd1;
	localparam logic [1:0] MODE_BLINK = 2'd2;
	localparam logic [1:0] MODE_FLOW  = 2'd3;

	// Result kinds.
	localparam logic KIND_RANGE = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// Colour codes.
	localparam logic [1:0] COLOR_NONE  = 2'd0;
	localparam logic [1:0] COLOR_SKY   = 2'd1;
	localparam logic [1:0] COLOR_GREEN = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_BLINK_HALF = 2'd0;
	localparam logic [1:0] CFG_REFRESH    = 2'd1;
	localparam logic [1:0] CFG_BRIGHTNESS = 2'd2;

	// Configuration reset values.
	localparam logic [15:0] RST_BLINK_HALF = 16'd250;
	localparam logic [15:0] RST_REFRESH    = 16'd100;
	localparam logic [7:0]  RST_BRIGHTNESS = 8'd10;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;       // input transaction taken this cycle
		logic flow_init;    // reset flow position of the latched segment
		logic ptr_clear;    // return the segment walk to the first segment
		logic ptr_step;     // move the segment walk on by one
		logic load_seg;     // load a range write for the current segment
		logic load_flush;   // load a strip flush
		logic flush_strip;  // strip targeted by the flush
		logic last;         // final result of this input
	} lse_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_tick;     // latched request is a tick
		logic req_mode_flow;// latched request sets flow mode on a valid segment
		logic blink_go;     // this tick redraws the blinking segments
		logic full_go;      // this tick redraws every segment
		logic seg_blink;    // current segment is in blink mode
		logic ptr_last;     // current segment is the last of the walk
		logic drawn0;       // a blink segment of strip one was drawn
		logic drawn1;       // a blink segment of strip two was drawn
		logic out_free;     // output register can take a result
	} lse_sts_t;

endpackage

### src/led_segment_effect_engine.sv
// Sequence: an accepted tick is decoded, then a full redraw loads its first result from the walk
// state that follows decode, and a blink redraw once the walk reaches the first blinking segment.
// Mode and bound writes pass through decode and give no result.
// Each redraw walks every segment of both strips and then the strip flushes; a blink redraw may be
// followed by a full redraw, output stalls hold the walk, and no new input is taken until idle.
// Reset: modes off, default layout, flow at start, phase one, timers and output clear, 250/100/10.
// ----------------------------------------------------------------------------
// led_segment_effect_engine
// Drives sixteen LED segments on two strips with off, on, blink and flow
// effects, producing range writes and strip flushes on each redraw.
// ----------------------------------------------------------------------------
module led_segment_effect_engine #(
	parameter int SEGS_PER_STRIP = lse_pkg::DEF_SEGS_PER_STRIP,
	parameter int LED_INDEX_BITS = lse_pkg::DEF_LED_INDEX_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  req_type,
	input  logic [3:0]                  seg_index,
	input  logic [1:0]                  new_mode,
	input  logic [6:0]                  new_start,
	input  logic [6:0]                  new_end,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [15:0]                 cfg_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        out_kind,
	output logic                        strip_sel,
	output logic [lse_pkg::RANGE_W-1:0] range_first,
	output logic [lse_pkg::RANGE_W-1:0] range_last,
	output logic [1:0]                  color_code,
	output logic                        level_full,
	output logic [7:0]                  brightness,
	output logic                        last_of_run
);
	import lse_pkg::*;

	lse_cmd_t cmd;
	lse_sts_t sts;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	// Controller.
	lse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath.
	lse_datapath #(
		.SEGS_PER_STRIP (SEGS_PER_STRIP),
		.LED_INDEX_BITS (LED_INDEX_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.seg_index   (seg_index),
		.new_mode    (new_mode),
		.new_start   (new_start),
		.new_end     (new_end),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_kind    (out_kind),
		.strip_sel   (strip_sel),
		.range_first (range_first),
		.range_last  (range_last),
		.color_code  (color_code),
		.level_full  (level_full),
		.brightness  (brightness),
		.last_of_run (last_of_run)
	);

	// A result is only loaded when the output register can take it.
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_seg || cmd.load_flush) |-> sts.out_free)
		else $error("result loaded into an occupied output register");

	// A flush carries no range, colour or level.
	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind == KIND_FLUSH) |->
		(range_first == '0 && range_last == '0 && color_code == COLOR_NONE && !level_full))
		else $error("flush transaction carries range data");

	// The final result of a run is always a flush.
	a_last_is_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_run) |-> (out_kind == KIND_FLUSH))
		else $error("run ends on a range write");

	// An accepted input is followed by a busy decode state.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken without a decode cycle");

endmodule

### src/lse_ctrl.sv
// ----------------------------------------------------------------------------
// lse_ctrl
// Controller: sequences request decode, the blink redraw walk, the full
// redraw walk and the strip flushes.
// ----------------------------------------------------------------------------
module lse_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  lse_pkg::lse_sts_t sts,
	output lse_pkg::lse_cmd_t cmd
);
	import lse_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_BLINK_SEG,
		ST_BLINK_FL0,
		ST_BLINK_FL1,
		ST_FULL_SEG,
		ST_FULL_FL0,
		ST_FULL_FL1
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Input is taken only while idle.
	assign in_stall = (state_q != ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.req_tick) begin
					cmd.ptr_clear = 1'b1;
					if (sts.blink_go) begin
						state_nxt = ST_BLINK_SEG;
					end else if (sts.full_go) begin
						state_nxt = ST_FULL_SEG;
					end else begin
						state_nxt = ST_IDLE;
					end
				end else begin
					cmd.flow_init = sts.req_mode_flow;
					state_nxt     = ST_IDLE;
				end
			end
			ST_BLINK_SEG: begin
				// Segments not blinking are skipped without a result.
				if (!sts.seg_blink || sts.out_free) begin
					cmd.load_seg = sts.seg_blink;
					cmd.ptr_step = 1'b1;
					if (sts.ptr_last) begin
						state_nxt = ST_BLINK_FL0;
					end
				end
			end
			ST_BLINK_FL0: begin
				if (!sts.drawn0) begin
					state_nxt = ST_BLINK_FL1;
				end else if (sts.out_free) begin
					cmd.load_flush  = 1'b1;
					cmd.flush_strip = 1'b0;
					cmd.last        = !sts.drawn1 && !sts.full_go;
					state_nxt       = ST_BLINK_FL1;
				end
			end
			ST_BLINK_FL1: begin
				if (!sts.drawn1 || sts.out_free) begin
					cmd.load_flush  = sts.drawn1;
					cmd.flush_strip = 1'b1;
					cmd.last        = !sts.full_go;
					cmd.ptr_clear   = 1'b1;
					state_nxt       = sts.full_go ? ST_FULL_SEG : ST_IDLE;
				end
			end
			ST_FULL_SEG: begin
				if (sts.out_free) begin
					cmd.load_seg = 1'b1;
					cmd.ptr_step = 1'b1;
					if (sts.ptr_last) begin
						state_nxt = ST_FULL_FL0;
					end
				end
			end
			ST_FULL_FL0: begin
				if (sts.out_free) begin
					cmd.load_flush  = 1'b1;
					cmd.flush_strip = 1'b0;
					state_nxt       = ST_FULL_FL1;
				end
			end
			ST_FULL_FL1: begin
				if (sts.out_free) begin
					cmd.load_flush  = 1'b1;
					cmd.flush_strip = 1'b1;
					cmd.last        = 1'b1;
					state_nxt       = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

### src/lse_datapath.sv
// ----------------------------------------------------------------------------
// lse_datapath
// Datapath: segment tables, blink and refresh timers, configuration
// registers, segment walk pointer and the result output register.
// ----------------------------------------------------------------------------
module lse_datapath #(
	parameter int SEGS_PER_STRIP = lse_pkg::DEF_SEGS_PER_STRIP,
	parameter int LED_INDEX_BITS = lse_pkg::DEF_LED_INDEX_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lse_pkg::lse_cmd_t         cmd,
	output lse_pkg::lse_sts_t         sts,
	input  logic [1:0]                req_type,
	input  logic [3:0]                seg_index,
	input  logic [1:0]                new_mode,
	input  logic [6:0]                new_start,
	input  logic [6:0]                new_end,
	input  logic                      cfg_valid,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      out_stall,
	output logic                      out_valid,
	output logic                      out_kind,
	output logic                      strip_sel,
	output logic [lse_pkg::RANGE_W-1:0] range_first,
	output logic [lse_pkg::RANGE_W-1:0] range_last,
	output logic [1:0]                color_code,
	output logic                      level_full,
	output logic [7:0]                brightness,
	output logic                      last_of_run
);
	import lse_pkg::*;

	localparam int TOTAL = 2 * SEGS_PER_STRIP;
	localparam int SW    = $clog2(TOTAL);
	localparam int KW    = (SEGS_PER_STRIP > 1) ? $clog2(SEGS_PER_STRIP) : 1;
	localparam int LW    = LED_INDEX_BITS;

	localparam logic [6:0] LAYOUT_START [2][8] = '{
		'{7'd0, 7'd8, 7'd16, 7'd24, 7'd36, 7'd44, 7'd50, 7'd56},
		'{7'd0, 7'd8, 7'd16, 7'd22, 7'd28, 7'd36, 7'd43, 7'd51}
	};
	localparam logic [6:0] LAYOUT_END [2][8] = '{
		'{7'd7, 7'd15, 7'd23, 7'd31, 7'd43, 7'd49, 7'd55, 7'd61},
		'{7'd7, 7'd15, 7'd21, 7'd27, 7'd35, 7'd42, 7'd50, 7'd58}
	};

	// Default layout bound of segment i; segments past the eighth of a strip use 0-0.
	function automatic logic [LW-1:0] def_bound(input int i, input logic want_end);
		int         k;
		int         s;
		logic [6:0] v;
		s = (i >= SEGS_PER_STRIP) ? 1 : 0;
		k = i - s * SEGS_PER_STRIP;
		v = 7'd0;
		if (k < 8) begin
			v = want_end ? LAYOUT_END[s][k[2:0]] : LAYOUT_START[s][k[2:0]];
		end
		return LW'(v);
	endfunction

	// Segment tables.
	logic [1:0]    mode_q  [TOTAL];
	logic [LW-1:0] start_q [TOTAL];
	logic [LW-1:0] end_q   [TOTAL];
	logic [LW-1:0] flow_q  [TOTAL];

	// Configuration registers.
	logic [15:0] blink_half_q;
	logic [15:0] refresh_period_q;
	logic [7:0]  brightness_q;

	// Timers.
	logic        blink_phase_q;
	logic [15:0] blink_elapsed_q;
	logic [15:0] refresh_elapsed_q;
	logic        blink_go_q;
	logic        full_go_q;

	// Latched request.
	logic [1:0]    type_q;
	logic [1:0]    mode_req_q;
	logic [SW-1:0] idx_q;
	logic          idx_ok_q;

	// Segment walk.
	logic [KW-1:0] k_q;
	logic          strip_q;
	logic [1:0]    drawn_q;

	// Output register.
	logic                out_valid_q;
	logic                out_kind_q;
	logic                strip_sel_q;
	logic [RANGE_W-1:0]  range_first_q;
	logic [RANGE_W-1:0]  range_last_q;
	logic [1:0]          color_q;
	logic                level_q;
	logic [7:0]          bright_q;
	logic                last_q;

	logic [TOTAL-1:0] blink_vec;
	logic             any_blink;
	logic             in_idx_ok;
	logic [SW-1:0]    in_idx;
	logic [SW-1:0]    seg_ptr;
	logic [SW-1:0]    rd_addr;
	logic [1:0]       rd_mode;
	logic [LW-1:0]    rd_start;
	logic [LW-1:0]    rd_end;
	logic [LW-1:0]    rd_flow;
	logic [LW:0]      flow_next;
	logic             flow_wrap;
	logic [16:0]      blink_next;
	logic [16:0]      refresh_next;
	logic             out_free;
	logic [LW-1:0]    seg_last;
	logic [1:0]       seg_color;
	logic             seg_level;
	logic [1:0]       strip_color;

	// Blink flags of all segments and their union.
	always_comb begin
		for (int i = 0; i < TOTAL; i++) begin
			blink_vec[i] = (mode_q[i] == MODE_BLINK);
		end
	end
	assign any_blink = |blink_vec;

	// Incoming segment index and its range check.
	assign in_idx_ok = (6'(seg_index) < 6'(TOTAL));
	assign in_idx    = SW'(seg_index);

	// Walk order is strip one then strip two for each position in the strip.
	assign seg_ptr = strip_q ? (SW'(SEGS_PER_STRIP) + SW'(k_q)) : SW'(k_q);
	assign rd_addr = cmd.flow_init ? idx_q : seg_ptr;

	assign rd_mode  = mode_q[rd_addr];
	assign rd_start = start_q[rd_addr];
	assign rd_end   = end_q[rd_addr];
	assign rd_flow  = flow_q[rd_addr];

	// Flow growth compare one bit wider than the index so it never wraps.
	assign flow_next = (LW+1)'(rd_flow) + (LW+1)'(1);
	assign flow_wrap = flow_next > {1'b0, rd_end};

	assign strip_color = strip_q ? COLOR_GREEN : COLOR_SKY;

	// Range write contents of the current segment.
	always_comb begin
		seg_last  = rd_end;
		seg_color = COLOR_NONE;
		seg_level = 1'b0;
		case (rd_mode)
			MODE_ON: begin
				seg_color = strip_color;
				seg_level = 1'b1;
			end
			MODE_BLINK: begin
				seg_color = blink_phase_q ? strip_color : COLOR_NONE;
				seg_level = blink_phase_q;
			end
			MODE_FLOW: begin
				seg_level = 1'b1;
				if (!flow_wrap) begin
					seg_last  = flow_next[LW-1:0];
					seg_color = strip_color;
				end
			end
			default: begin
				seg_color = COLOR_NONE;
			end
		endcase
	end

	assign blink_next   = 17'(blink_elapsed_q) + 17'd1;
	assign refresh_next = 17'(refresh_elapsed_q) + 17'd1;
	assign out_free     = !out_valid_q || !out_stall;

	// Segment tables: mode and bound writes, flow position updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TOTAL; i++) begin
				mode_q[i]  <= MODE_OFF;
				start_q[i] <= def_bound(i, 1'b0);
				end_q[i]   <= def_bound(i, 1'b1);
				flow_q[i]  <= def_bound(i, 1'b0);
			end
		end else begin
			if (cmd.accept && in_idx_ok) begin
				if (req_type == REQ_MODE) begin
					mode_q[in_idx] <= new_mode;
				end else if (req_type == REQ_BOUNDS) begin
					start_q[in_idx] <= LW'(new_start);
					end_q[in_idx]   <= LW'(new_end);
				end
			end
			if (cmd.flow_init) begin
				flow_q[rd_addr] <= rd_start;
			end else if (cmd.load_seg && rd_mode == MODE_FLOW) begin
				flow_q[rd_addr] <= flow_wrap ? rd_start : flow_next[LW-1:0];
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_half_q     <= RST_BLINK_HALF;
			refresh_period_q <= RST_REFRESH;
			brightness_q     <= RST_BRIGHTNESS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BLINK_HALF: blink_half_q     <= cfg_data;
				CFG_REFRESH:    refresh_period_q <= cfg_data;
				CFG_BRIGHTNESS: brightness_q     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Request latch, updated on every accepted input, and the blink and refresh timers, updated on a tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q            <= REQ_TICK;
			mode_req_q        <= MODE_OFF;
			idx_q             <= '0;
			idx_ok_q          <= 1'b0;
			blink_phase_q     <= 1'b1;
			blink_elapsed_q   <= '0;
			refresh_elapsed_q <= '0;
			blink_go_q        <= 1'b0;
			full_go_q         <= 1'b0;
		end else if (cmd.accept) begin
			type_q     <= req_type;
			mode_req_q <= new_mode;
			idx_q      <= in_idx;
			idx_ok_q   <= in_idx_ok;
			if (req_type == REQ_TICK) begin
				if (!any_blink) begin
					blink_phase_q   <= 1'b1;
					blink_elapsed_q <= '0;
					blink_go_q      <= 1'b0;
				end else if (blink_next >= {1'b0, blink_half_q}) begin
					blink_phase_q   <= !blink_phase_q;
					blink_elapsed_q <= '0;
					blink_go_q      <= 1'b1;
				end else begin
					blink_elapsed_q <= blink_next[15:0];
					blink_go_q      <= 1'b0;
				end
				if (refresh_next > {1'b0, refresh_period_q}) begin
					refresh_elapsed_q <= '0;
					full_go_q         <= 1'b1;
				end else begin
					refresh_elapsed_q <= refresh_next[15:0];
					full_go_q         <= 1'b0;
				end
			end
		end
	end

	// Segment walk pointer and per-strip drawn flags of the blink walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			strip_q <= 1'b0;
			drawn_q <= '0;
		end else begin
			if (cmd.accept) begin
				drawn_q <= '0;
			end else if (cmd.load_seg) begin
				drawn_q[strip_q] <= 1'b1;
			end
			if (cmd.ptr_clear) begin
				k_q     <= '0;
				strip_q <= 1'b0;
			end else if (cmd.ptr_step) begin
				strip_q <= !strip_q;
				if (strip_q) begin
					k_q <= k_q + KW'(1);
				end
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_seg || cmd.load_flush) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_kind_q    <= KIND_RANGE;
			strip_sel_q   <= 1'b0;
			range_first_q <= '0;
			range_last_q  <= '0;
			color_q       <= COLOR_NONE;
			level_q       <= 1'b0;
			bright_q      <= '0;
			last_q        <= 1'b0;
		end else if (cmd.load_seg) begin
			out_kind_q    <= KIND_RANGE;
			strip_sel_q   <= strip_q;
			range_first_q <= RANGE_W'(rd_start);
			range_last_q  <= RANGE_W'(seg_last);
			color_q       <= seg_color;
			level_q       <= seg_level;
			bright_q      <= brightness_q;
			last_q        <= 1'b0;
		end else if (cmd.load_flush) begin
			out_kind_q    <= KIND_FLUSH;
			strip_sel_q   <= cmd.flush_strip;
			range_first_q <= '0;
			range_last_q  <= '0;
			color_q       <= COLOR_NONE;
			level_q       <= 1'b0;
			bright_q      <= brightness_q;
			last_q        <= cmd.last;
		end
	end

	// Status to the controller.
	assign sts.req_tick      = (type_q == REQ_TICK);
	assign sts.req_mode_flow = (type_q == REQ_MODE) && idx_ok_q && (mode_req_q == MODE_FLOW);
	assign sts.blink_go      = blink_go_q;
	assign sts.full_go       = full_go_q;
	assign sts.seg_blink     = (rd_mode == MODE_BLINK);
	assign sts.ptr_last      = strip_q && (k_q == KW'(SEGS_PER_STRIP - 1));
	assign sts.drawn0        = drawn_q[0];
	assign sts.drawn1        = drawn_q[1];
	assign sts.out_free      = out_free;

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign strip_sel   = strip_sel_q;
	assign range_first = range_first_q;
	assign range_last  = range_last_q;
	assign color_code  = color_q;
	assign level_full  = level_q;
	assign brightness  = bright_q;
	assign last_of_run = last_q;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED segment effect engine. A directed table of
// requests and register writes runs first, then random phases of ticks, mode
// and bound writes under several timer settings. Every result transaction is
// compared with the output of a behavioural predictor of the segment effects.
// ----------------------------------------------------------------------------
module testbench;
	import lse_pkg::*;

	localparam int SEGS           = DEF_SEGS_PER_STRIP;
	localparam int NUM_SEGS       = 2 * SEGS;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;
	localparam int PHASES         = 5;
	localparam int PHASE_ITEMS    = 44;

	// Codes that the package leaves unnamed.
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// Default segment layout, strip one then strip two.
	localparam logic [6:0] LAYOUT_FIRST [NUM_SEGS] = '{
		7'd0, 7'd8, 7'd16, 7'd24, 7'd36, 7'd44, 7'd50, 7'd56,
		7'd0, 7'd8, 7'd16, 7'd22, 7'd28, 7'd36, 7'd43, 7'd51};
	localparam logic [6:0] LAYOUT_LAST [NUM_SEGS] = '{
		7'd7, 7'd15, 7'd23, 7'd31, 7'd43, 7'd49, 7'd55, 7'd61,
		7'd7, 7'd15, 7'd21, 7'd27, 7'd35, 7'd42, 7'd50, 7'd58};

	// One LED write or strip flush as it leaves the block.
	typedef struct packed {
		logic       kind;
		logic       strip;
		logic [6:0] first;
		logic [6:0] last;
		logic [1:0] colour;
		logic       level;
		logic [7:0] bright;
		logic       run_end;
	} led_write_t;

	// One row of stimulus: a request or a register write. A row marked as
	// typed carries its own expectation: nothing, or one range write
	// followed by the flush of the same strip.
	typedef struct packed {
		logic        is_cfg;
		logic [1:0]  rt;
		logic [3:0]  seg;
		logic [1:0]  mode;
		logic [6:0]  st;
		logic [6:0]  en;
		logic [1:0]  cfg_idx;
		logic [15:0] cfg_val;
		logic        typed;
		logic        drawn;
		led_write_t  shown;
	} stim_row_t;

	// Clock, reset and block ports.
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = '0;
	logic [3:0]  seg_index = '0;
	logic [1:0]  new_mode = '0;
	logic [6:0]  new_start = '0;
	logic [6:0]  new_end = '0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        out_kind;
	logic        strip_sel;
	logic [6:0]  range_first;
	logic [6:0]  range_last;
	logic [1:0]  color_code;
	logic        level_full;
	logic [7:0]  brightness;
	logic        last_of_run;

	// Predictor state and configuration.
	logic [1:0]  seg_mode  [NUM_SEGS];
	logic [6:0]  seg_first [NUM_SEGS];
	logic [6:0]  seg_last  [NUM_SEGS];
	logic [6:0]  flow_head [NUM_SEGS];
	logic        blink_lit;
	logic [15:0] blink_wait;
	logic [15:0] refresh_wait;
	logic [15:0] half_period;
	logic [15:0] redraw_period;
	logic [7:0]  led_brightness;

	led_write_t new_writes [$];
	led_write_t pending_writes [$];
	stim_row_t  directed [$];
	led_write_t seen;
	led_write_t want;

	bit calm = 1'b0;
	int fail_count = 0;
	int checked_writes = 0;
	int items_sent = 0;
	int ticks_sent = 0;
	int cfg_writes = 0;
	int largest_burst = 0;
	int idle_cycles = 0;

	led_segment_effect_engine dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.seg_index  (seg_index),
		.new_mode   (new_mode),
		.new_start  (new_start),
		.new_end    (new_end),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_kind   (out_kind),
		.strip_sel  (strip_sel),
		.range_first(range_first),
		.range_last (range_last),
		.color_code (color_code),
		.level_full (level_full),
		.brightness (brightness),
		.last_of_run(last_of_run)
	);

	always #6 clk = ~clk;

	// Appends one predicted write, stamped with the current brightness.
	function automatic void queue_write(logic kind, logic strip, logic [6:0] first,
			logic [6:0] last, logic [1:0] colour, logic level);
		led_write_t w;
		w.kind    = kind;
		w.strip   = strip;
		w.first   = first;
		w.last    = last;
		w.colour  = colour;
		w.level   = level;
		w.bright  = led_brightness;
		w.run_end = 1'b0;
		new_writes.push_back(w);
	endfunction

	// Draws one segment; flow segments only move and draw on a full redraw.
	function automatic void draw_one_segment(int s, bit advance);
		logic       strip;
		logic [1:0] colour;
		logic [7:0] step;
		strip  = (s >= SEGS);
		colour = strip ? COLOR_GREEN : COLOR_SKY;
		case (seg_mode[s])
			MODE_OFF: queue_write(KIND_RANGE, strip, seg_first[s], seg_last[s], COLOR_NONE, 1'b0);
			MODE_ON:  queue_write(KIND_RANGE, strip, seg_first[s], seg_last[s], colour, 1'b1);
			MODE_BLINK: begin
				if (blink_lit)
					queue_write(KIND_RANGE, strip, seg_first[s], seg_last[s], colour, 1'b1);
				else
					queue_write(KIND_RANGE, strip, seg_first[s], seg_last[s], COLOR_NONE, 1'b0);
			end
			default: begin
				if (advance) begin
					// The comparison is one bit wider than the LED index.
					step = {1'b0, flow_head[s]} + 8'd1;
					if (step > {1'b0, seg_last[s]}) begin
						flow_head[s] = seg_first[s];
						queue_write(KIND_RANGE, strip, seg_first[s], seg_last[s], COLOR_NONE, 1'b1);
					end else begin
						flow_head[s] = step[6:0];
						queue_write(KIND_RANGE, strip, seg_first[s], flow_head[s], colour, 1'b1);
					end
				end
			end
		endcase
	endfunction

	// Works out the LED writes that one request causes and updates the state.
	function automatic void compute_led_writes(logic [1:0] rt, logic [3:0] seg,
			logic [1:0] mode, logic [6:0] st, logic [6:0] en);
		bit          any_blink;
		bit          drew0;
		bit          drew1;
		logic [16:0] count;
		led_write_t  w;
		new_writes.delete();
		case (rt)
			REQ_TICK: begin
				any_blink = 1'b0;
				for (int i = 0; i < NUM_SEGS; i++)
					if (seg_mode[i] == MODE_BLINK)
						any_blink = 1'b1;
				// Blink phase: held lit while nothing blinks.
				if (!any_blink) begin
					blink_lit  = 1'b1;
					blink_wait = '0;
				end else begin
					count = {1'b0, blink_wait} + 17'd1;
					if (count >= {1'b0, half_period}) begin
						blink_wait = '0;
						blink_lit  = ~blink_lit;
						drew0      = 1'b0;
						drew1      = 1'b0;
						for (int i = 0; i < SEGS; i++) begin
							if (seg_mode[i] == MODE_BLINK) begin
								draw_one_segment(i, 1'b0);
								drew0 = 1'b1;
							end
							if (seg_mode[SEGS + i] == MODE_BLINK) begin
								draw_one_segment(SEGS + i, 1'b0);
								drew1 = 1'b1;
							end
						end
						if (drew0)
							queue_write(KIND_FLUSH, 1'b0, '0, '0, COLOR_NONE, 1'b0);
						if (drew1)
							queue_write(KIND_FLUSH, 1'b1, '0, '0, COLOR_NONE, 1'b0);
					end else begin
						blink_wait = count[15:0];
					end
				end
				// Full redraw once the refresh period has been exceeded.
				count = {1'b0, refresh_wait} + 17'd1;
				if (count > {1'b0, redraw_period}) begin
					refresh_wait = '0;
					for (int i = 0; i < SEGS; i++) begin
						draw_one_segment(i, 1'b1);
						draw_one_segment(SEGS + i, 1'b1);
					end
					queue_write(KIND_FLUSH, 1'b0, '0, '0, COLOR_NONE, 1'b0);
					queue_write(KIND_FLUSH, 1'b1, '0, '0, COLOR_NONE, 1'b0);
				end else begin
					refresh_wait = count[15:0];
				end
			end
			REQ_MODE: begin
				seg_mode[seg] = mode;
				if (mode == MODE_FLOW)
					flow_head[seg] = seg_first[seg];
			end
			REQ_BOUNDS: begin
				seg_first[seg] = st;
				seg_last[seg]  = en;
			end
			default: ;
		endcase
		if (new_writes.size() > 0) begin
			w = new_writes.pop_back();
			w.run_end = 1'b1;
			new_writes.push_back(w);
		end
	endfunction

	function automatic string describe(led_write_t w);
		return $sformatf("kind=%0d strip=%0d range=%0d..%0d colour=%0d level=%0d bright=%0d last=%0d",
			w.kind, w.strip, w.first, w.last, w.colour, w.level, w.bright, w.run_end);
	endfunction

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	// Row builders for the directed table.
	function automatic stim_row_t item_row(logic [1:0] rt, logic [3:0] seg, logic [1:0] mode,
			logic [6:0] st, logic [6:0] en);
		stim_row_t r;
		r      = '0;
		r.rt   = rt;
		r.seg  = seg;
		r.mode = mode;
		r.st   = st;
		r.en   = en;
		return r;
	endfunction

	function automatic stim_row_t quiet_row(logic [1:0] rt, logic [3:0] seg, logic [1:0] mode,
			logic [6:0] st, logic [6:0] en);
		stim_row_t r;
		r       = item_row(rt, seg, mode, st, en);
		r.typed = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t tick_drawing(logic strip, logic [6:0] first, logic [6:0] last,
			logic [1:0] colour, logic level, logic [7:0] bright);
		stim_row_t r;
		r       = item_row(REQ_TICK, 4'd0, MODE_OFF, 7'd0, 7'd0);
		r.typed = 1'b1;
		r.drawn = 1'b1;
		r.shown = led_write_t'{KIND_RANGE, strip, first, last, colour, level, bright, 1'b0};
		return r;
	endfunction

	function automatic stim_row_t cfg_row(logic [1:0] idx, logic [15:0] val);
		stim_row_t r;
		r         = '0;
		r.is_cfg  = 1'b1;
		r.cfg_idx = idx;
		r.cfg_val = val;
		return r;
	endfunction

	// A random request: mostly ticks, with mode and bound writes mixed in.
	function automatic stim_row_t random_request();
		stim_row_t r;
		int        pick;
		r      = '0;
		r.seg  = 4'($urandom_range(15));
		r.mode = 2'($urandom_range(3));
		r.st   = 7'($urandom_range(127));
		r.en   = 7'($urandom_range(127));
		pick   = $urandom_range(99);
		if (pick < 62) begin
			r.rt = REQ_TICK;
		end else if (pick < 80) begin
			r.rt = REQ_MODE;
		end else if (pick < 95) begin
			r.rt = REQ_BOUNDS;
			// Most bound writes describe a short, ordinary segment.
			if ($urandom_range(9) < 7) begin
				r.st = 7'($urandom_range(120));
				r.en = r.st + 7'($urandom_range(7));
			end
		end else begin
			r.rt = REQ_UNUSED;
		end
		return r;
	endfunction

	// Timer setting for a random phase, with the extremes among the choices.
	function automatic logic [15:0] pick_period();
		case ($urandom_range(7))
			0:       return 16'd0;
			1:       return 16'hFFFF;
			2:       return 16'($urandom_range(65535));
			default: return 16'($urandom_range(1, 8));
		endcase
	endfunction

	// Presents one request, waits for its transaction and records what it causes.
	task automatic send_request(input stim_row_t r);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		req_type  <= r.rt;
		seg_index <= r.seg;
		new_mode  <= r.mode;
		new_start <= r.st;
		new_end   <= r.en;
		do @(posedge clk); while (in_stall);
		compute_led_writes(r.rt, r.seg, r.mode, r.st, r.en);
		if (r.typed) begin
			new_writes.delete();
			if (r.drawn) begin
				new_writes.push_back(r.shown);
				new_writes.push_back(led_write_t'{KIND_FLUSH, r.shown.strip, 7'd0, 7'd0,
					COLOR_NONE, 1'b0, r.shown.bright, 1'b1});
			end
		end
		items_sent++;
		if (r.rt == REQ_TICK)
			ticks_sent++;
		if (new_writes.size() > largest_burst)
			largest_burst = new_writes.size();
		foreach (new_writes[i])
			pending_writes.push_back(new_writes[i]);
	endtask

	// Holds the sender off until every expected write has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write transaction; the block is idle when this is called.
	task automatic write_register(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BLINK_HALF: half_period    = val;
			CFG_REFRESH:    redraw_period  = val;
			CFG_BRIGHTNESS: led_brightness = val[7:0];
			default: ;
		endcase
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Result side: random stall, and a check of every result transaction.
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 9);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen = {out_kind, strip_sel, range_first, range_last, color_code, level_full,
				brightness, last_of_run};
			checked_writes++;
			if (pending_writes.size() == 0) begin
				note_failure($sformatf("unexpected result: %s", describe(seen)));
			end else begin
				want = pending_writes.pop_front();
				if (seen !== want)
					note_failure($sformatf("result %0d mismatch: expected %s, got %s",
						checked_writes, describe(want), describe(seen)));
			end
		end
	end

	// Watchdog on cycles in which no transaction of any kind happens.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", idle_cycles);
			$display("** led_segment_effect_engine: FAILED **");
			$finish;
		end
	end

	// Main sequence.
	initial begin
		int sent;

		// Predictor after reset.
		for (int i = 0; i < NUM_SEGS; i++) begin
			seg_mode[i]  = MODE_OFF;
			seg_first[i] = LAYOUT_FIRST[i];
			seg_last[i]  = LAYOUT_LAST[i];
			flow_head[i] = LAYOUT_FIRST[i];
		end
		blink_lit      = 1'b1;
		blink_wait     = '0;
		refresh_wait   = '0;
		half_period    = RST_BLINK_HALF;
		redraw_period  = RST_REFRESH;
		led_brightness = RST_BRIGHTNESS;

		// Directed table: reset defaults, every mode, bound extremes, flow wrap,
		// start after end, timers at zero and at full scale.
		directed.push_back(quiet_row(REQ_TICK, 4'd0, MODE_OFF, 7'd0, 7'd0));
		directed.push_back(quiet_row(REQ_UNUSED, 4'd15, MODE_FLOW, 7'd127, 7'd127));
		directed.push_back(quiet_row(REQ_MODE, 4'd0, MODE_BLINK, 7'd0, 7'd0));
		directed.push_back(cfg_row(CFG_BLINK_HALF, 16'd1));
		directed.push_back(tick_drawing(1'b0, 7'd0, 7'd7, COLOR_NONE, 1'b0, 8'd10));
		directed.push_back(tick_drawing(1'b0, 7'd0, 7'd7, COLOR_SKY, 1'b1, 8'd10));
		directed.push_back(quiet_row(REQ_BOUNDS, 4'd15, MODE_OFF, 7'd127, 7'd0));
		directed.push_back(quiet_row(REQ_MODE, 4'd15, MODE_BLINK, 7'd0, 7'd0));
		directed.push_back(item_row(REQ_TICK, 4'd0, MODE_OFF, 7'd0, 7'd0));
		directed.push_back(quiet_row(REQ_BOUNDS, 4'd12, MODE_OFF, 7'd127, 7'd127));
		directed.push_back(quiet_row(REQ_MODE, 4'd12, MODE_FLOW, 7'd0, 7'd0));
		directed.push_back(quiet_row(REQ_BOUNDS, 4'd3, MODE_OFF, 7'd10, 7'd5));
		directed.push_back(quiet_row(REQ_MODE, 4'd3, MODE_FLOW, 7'd0, 7'd0));
		directed.push_back(quiet_row(REQ_MODE, 4'd8, MODE_ON, 7'd0, 7'd0));
		directed.push_back(quiet_row(REQ_BOUNDS, 4'd5, MODE_OFF, 7'd0, 7'd127));
		directed.push_back(quiet_row(REQ_MODE, 4'd5, MODE_FLOW, 7'd0, 7'd0));
		directed.push_back(quiet_row(REQ_BOUNDS, 4'd5, MODE_OFF, 7'd2, 7'd9));
		directed.push_back(cfg_row(CFG_BRIGHTNESS, 16'd255));
		directed.push_back(cfg_row(CFG_REFRESH, 16'd0));
		directed.push_back(cfg_row(CFG_UNUSED, 16'hFFFF));
		directed.push_back(item_row(REQ_TICK, 4'd15, MODE_FLOW, 7'd127, 7'd127));
		directed.push_back(item_row(REQ_TICK, 4'd0, MODE_OFF, 7'd0, 7'd0));
		directed.push_back(item_row(REQ_TICK, 4'd7, MODE_ON, 7'd64, 7'd32));
		directed.push_back(cfg_row(CFG_BLINK_HALF, 16'd0));
		directed.push_back(cfg_row(CFG_REFRESH, 16'hFFFF));
		directed.push_back(cfg_row(CFG_BRIGHTNESS, 16'd0));
		directed.push_back(item_row(REQ_TICK, 4'd0, MODE_OFF, 7'd0, 7'd0));
		directed.push_back(item_row(REQ_TICK, 4'd0, MODE_OFF, 7'd0, 7'd0));
		directed.push_back(quiet_row(REQ_MODE, 4'd15, MODE_OFF, 7'd0, 7'd0));
		directed.push_back(quiet_row(REQ_MODE, 4'd0, MODE_OFF, 7'd0, 7'd0));
		directed.push_back(quiet_row(REQ_TICK, 4'd0, MODE_OFF, 7'd0, 7'd0));

		// Reset, once.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; register writes only once the block is idle.
		foreach (directed[k]) begin
			if (directed[k].is_cfg) begin
				drain_results();
				write_register(directed[k].cfg_idx, directed[k].cfg_val);
			end else begin
				send_request(directed[k]);
			end
		end

		// Random phases, each under its own timer and brightness setting.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			write_register(CFG_BLINK_HALF, pick_period());
			write_register(CFG_REFRESH, pick_period());
			write_register(CFG_BRIGHTNESS, 16'($urandom_range(65535)));
			calm = (phase == 2);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				send_request(random_request());
				if (req_type != REQ_UNUSED)
					sent++;
				// Part way into the first phase the sender waits for all results.
				if (phase == 0 && sent == PHASE_ITEMS / 2)
					drain_results();
			end
		end
		calm = 1'b0;

		drain_results();
		repeat (END_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d ticks) and %0d register writes over %0d phases.",
			items_sent, ticks_sent, cfg_writes, PHASES + 1);
		$display("Checked %0d result transactions; longest redraw burst %0d results.",
			checked_writes, largest_burst);
		if (fail_count == 0)
			$display("** led_segment_effect_engine: PASSED **");
		else
			$display("** led_segment_effect_engine: FAILED **");
		$finish;
	end

endmodule
